### src/bhpq_pkg.sv
package bhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int HW = $clog2(CW);
    localparam int KW = 31;
    localparam int SW = 31;
    localparam int PW = 32;

    localparam logic [1:0] ORD_MIN   = 2'd0;
    localparam logic [1:0] ORD_MAX   = 2'd1;
    localparam logic [1:0] ORD_STAMP = 2'd2;
    localparam logic [1:0] ORD_BAD   = 2'd3;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    typedef struct packed {
        logic [KW-1:0] key;
        logic [SW-1:0] stamp;
        logic [PW-1:0] payload;
    } t_entry;

    localparam int EW = $bits(t_entry);

    // a comes before b: bigger key, or equal key and smaller stamp
    function automatic logic stamp_first(input t_entry a, input t_entry b);
        stamp_first = (a.key > b.key) || ((a.key == b.key) && (a.stamp < b.stamp));
    endfunction

    // index of the highest set bit
    function automatic logic [HW-1:0] msb_index(input logic [CW-1:0] v);
        logic [HW-1:0] h;
        h = '0;
        for (int b = 0; b < CW; b++) begin
            if (v[b]) begin
                h = HW'(b);
            end
        end
        msb_index = h;
    endfunction

endpackage

### src/binary_heap_priority_queue.sv
// Priority queue held as a binary heap in one single-port-read RAM.
// Input channel: i_in_valid / o_in_stall carries operation, key, stamp and
// payload. Operation 0 inserts, 1 pops the top entry, 2 (and 3) peeks.
// Output channel: o_out_valid / i_out_stall returns one beat per item with the
// popped or peeked entry (root after the operation for an insert), found,
// full_reject and the entry count after the operation.
// Config channel: i_cfg_valid / o_cfg_ready writes heap_order; write it only
// while the block is idle. Code 3 acts as min order.
// One item is worked on at a time. The RAM read is registered: peek reads the
// root, insert walks the path from the root to the new leaf one node per read,
// and pop reads the last entry and sifts it down from the root one level at
// a time, reading each child that exists before it moves.
// The result sits in an output register: the next item is taken while it
// waits on a stalled receiver; a further result then holds until it drains.
// Reset empties the heap (count to zero) and selects min order; the RAM is
// not cleared, as only entries below the count are ever read. Both input
// channels hold off while reset is asserted.
module binary_heap_priority_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_operation,
    input  logic [bhpq_pkg::KW-1:0]   i_key,
    input  logic [bhpq_pkg::SW-1:0]   i_stamp,
    input  logic [bhpq_pkg::PW-1:0]   i_payload,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [bhpq_pkg::KW-1:0]   o_top_key,
    output logic [bhpq_pkg::SW-1:0]   o_top_stamp,
    output logic [bhpq_pkg::PW-1:0]   o_top_payload,
    output logic                      o_found,
    output logic                      o_full_reject,
    output logic [bhpq_pkg::CW-1:0]   o_entry_total,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_data
);

    localparam int AW = bhpq_pkg::AW;
    localparam int CW = bhpq_pkg::CW;
    localparam int HW = bhpq_pkg::HW;
    localparam int IW = AW + 2;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_INS_RD   = 13'b0000000000010,
        S_INS_CMP  = 13'b0000000000100,
        S_INS_LEAF = 13'b0000000001000,
        S_FIN_RD   = 13'b0000000010000,
        S_ROOT     = 13'b0000000100000,
        S_POP_TOP  = 13'b0000001000000,
        S_POP_LAST = 13'b0000010000000,
        S_SD_LOOP  = 13'b0000100000000,
        S_SD_L     = 13'b0001000000000,
        S_SD_R     = 13'b0010000000000,
        S_DONE     = 13'b0100000000000,
        S_SPARE    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]        r_order;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_q;
    logic [HW-1:0]     r_shift;
    logic [AW-1:0]     r_node;
    logic [IW-1:0]     r_i;
    bhpq_pkg::t_entry  r_carry;
    bhpq_pkg::t_entry  r_left;
    bhpq_pkg::t_entry  r_top;
    logic              r_found;
    logic              r_reject;

    logic              r_out_valid;
    bhpq_pkg::t_entry  r_out;
    logic              r_out_found;
    logic              r_out_reject;
    logic [CW-1:0]     r_out_total;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    bhpq_pkg::t_entry  ram_wdata, ram_rdata;

    logic              in_acc, out_load;
    logic [IW-1:0]     left_i, right_i;
    logic              left_in, right_in;
    logic              rises;
    logic              sd_swap, sd_right;
    logic [CW-1:0]     q_in;
    logic [HW-1:0]     h_in;
    logic [CW-1:0]     path_node;
    bhpq_pkg::t_entry  in_entry;

    bhpq_ram #(
        .WIDTH (bhpq_pkg::EW),
        .DEPTH (bhpq_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_cfg_ready = i_rst_n;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign in_entry  = '{key: i_key, stamp: i_stamp, payload: i_payload};
    assign q_in      = r_count + CW'(1);
    assign h_in      = bhpq_pkg::msb_index(q_in);
    assign path_node = (r_q >> r_shift) - CW'(1);

    assign left_i   = {r_i[IW-2:0], 1'b1};
    assign right_i  = left_i + IW'(1);
    assign left_in  = left_i < IW'(r_count);
    assign right_in = right_i < IW'(r_count);

    // carried entry belongs above the node just read
    always_comb begin
        case (r_order)
            bhpq_pkg::ORD_MAX:   rises = ram_rdata.key < r_carry.key;
            bhpq_pkg::ORD_STAMP: rises = bhpq_pkg::stamp_first(r_carry, ram_rdata);
            default:             rises = ram_rdata.key > r_carry.key;
        endcase
    end

    // sift-down decision; the S_SD_L branch is used only when no right child exists
    always_comb begin
        sd_swap  = 1'b0;
        sd_right = 1'b0;
        if (r_state == S_SD_R) begin
            case (r_order)
                bhpq_pkg::ORD_MAX: begin
                    sd_swap  = (r_carry.key <= r_left.key) || (r_carry.key <= ram_rdata.key);
                    sd_right = ram_rdata.key >= r_left.key;
                end
                bhpq_pkg::ORD_STAMP: begin
                    sd_right = !bhpq_pkg::stamp_first(r_left, ram_rdata)
                            && bhpq_pkg::stamp_first(ram_rdata, r_left);
                    sd_swap  = sd_right ? bhpq_pkg::stamp_first(ram_rdata, r_carry)
                                        : bhpq_pkg::stamp_first(r_left, r_carry);
                end
                default: begin
                    sd_swap  = (r_carry.key >= r_left.key) || (r_carry.key >= ram_rdata.key);
                    sd_right = ram_rdata.key <= r_left.key;
                end
            endcase
        end else begin
            case (r_order)
                bhpq_pkg::ORD_MAX:   sd_swap = r_carry.key <= ram_rdata.key;
                bhpq_pkg::ORD_STAMP: sd_swap = bhpq_pkg::stamp_first(ram_rdata, r_carry);
                default:             sd_swap = r_carry.key > ram_rdata.key;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_carry;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_operation == bhpq_pkg::OP_INSERT) begin
                        if (r_count >= CW'(bhpq_pkg::CAPACITY)) begin
                            ram_re  = 1'b1;
                            n_state = S_ROOT;
                        end else if (h_in == '0) begin
                            n_state = S_INS_LEAF;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end else if (r_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        ram_re  = 1'b1;
                        n_state = (i_operation == bhpq_pkg::OP_POP) ? S_POP_TOP : S_ROOT;
                    end
                end
            end
            S_INS_RD: begin
                ram_re    = 1'b1;
                ram_raddr = path_node[AW-1:0];
                n_state   = S_INS_CMP;
            end
            S_INS_CMP: begin
                ram_we    = rises;
                ram_waddr = r_node;
                n_state   = (r_shift == HW'(1)) ? S_INS_LEAF : S_INS_RD;
            end
            S_INS_LEAF: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[AW-1:0];
                n_state   = S_FIN_RD;
            end
            S_FIN_RD: begin
                ram_re  = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                n_state = S_DONE;
            end
            S_POP_TOP: begin
                if (r_count == CW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_count - CW'(1));
                    n_state   = S_POP_LAST;
                end
            end
            S_POP_LAST: begin
                n_state = S_SD_LOOP;
            end
            S_SD_LOOP: begin
                if (!left_in) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_i[AW-1:0];
                    n_state   = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = left_i[AW-1:0];
                    n_state   = S_SD_L;
                end
            end
            S_SD_L: begin
                if (right_in) begin
                    ram_re    = 1'b1;
                    ram_raddr = right_i[AW-1:0];
                    n_state   = S_SD_R;
                end else begin
                    // lift the child, or drop the carried entry here
                    ram_we    = 1'b1;
                    ram_waddr = r_i[AW-1:0];
                    ram_wdata = sd_swap ? ram_rdata : r_carry;
                    n_state   = sd_swap ? S_SD_LOOP : S_DONE;
                end
            end
            S_SD_R: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[AW-1:0];
                ram_wdata = !sd_swap ? r_carry : (sd_right ? ram_rdata : r_left);
                n_state   = sd_swap ? S_SD_LOOP : S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            S_SPARE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_order     <= bhpq_pkg::ORD_MIN;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_order <= (i_cfg_data == bhpq_pkg::ORD_BAD) ? bhpq_pkg::ORD_MIN : i_cfg_data;
            end
            if (r_state == S_INS_LEAF) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == S_POP_TOP) begin
                r_count <= r_count - CW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_carry  <= in_entry;
                r_q      <= q_in;
                r_shift  <= h_in;
                r_top    <= '0;
                r_found  <= 1'b0;
                r_reject <= (i_operation == bhpq_pkg::OP_INSERT)
                         && (r_count >= CW'(bhpq_pkg::CAPACITY));
            end
            S_INS_RD: begin
                r_node <= path_node[AW-1:0];
            end
            S_INS_CMP: begin
                if (rises) begin
                    r_carry <= ram_rdata;
                end
                r_shift <= r_shift - HW'(1);
            end
            S_ROOT: begin
                r_top   <= ram_rdata;
                r_found <= 1'b1;
            end
            S_POP_TOP: begin
                r_top   <= ram_rdata;
                r_found <= 1'b1;
            end
            S_POP_LAST: begin
                r_carry <= ram_rdata;
                r_i     <= '0;
            end
            S_SD_L: begin
                r_left <= ram_rdata;
                if (!right_in && sd_swap) begin
                    r_i <= left_i;
                end
            end
            S_SD_R: begin
                if (sd_swap) begin
                    r_i <= sd_right ? right_i : left_i;
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out        <= r_top;
            r_out_found  <= r_found;
            r_out_reject <= r_reject;
            r_out_total  <= r_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_top_key     = r_out.key;
    assign o_top_stamp   = r_out.stamp;
    assign o_top_payload = r_out.payload;
    assign o_found       = r_out_found;
    assign o_full_reject = r_out_reject;
    assign o_entry_total = r_out_total;

endmodule

### src/bhpq_ram.sv
module bhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
